FILE: hdl/tcw_pkg.sv
package tcw_pkg;

   localparam int MAX_COLS_DEF = 80;
   localparam int MAX_ROWS_DEF = 25;

   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int BYTE_W     = 8;
   localparam int CELL_W     = 16;
   localparam int POS_W      = 11;
   localparam int IDX_W      = COL_W + ROW_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;

   localparam logic REG_COLUMNS = 1'b0;
   localparam logic REG_ROWS    = 1'b1;

   localparam logic [COL_W-1:0] COLUMNS_RESET = 7'd80;
   localparam logic [ROW_W-1:0] ROWS_RESET    = 5'd25;

endpackage

FILE: hdl/text_console_writer.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    char_code, attribute
// rsp_      out        rsp_valid/stall    cursor_position, cell_written, cell_index, did_scroll
// csr_      in/out     APB, pready high   columns (0x0), rows (0x4)
//
// Accept does the cursor multiply; ST_WORK then writes the cell and loads the result,
// waiting while an older result is held by rsp_stall. A scrolling item then copies the cell
// memory one cell a cycle through its single read port, then drains, before a new item is taken.
// After reset a clearing pass zeroes all MAX_COLS * MAX_ROWS cells; req_stall is high meanwhile.
// The result register lets the next item be taken while a result waits on rsp_stall.
module text_console_writer #(
   parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tcw_pkg::BYTE_W-1:0]        req_char_code,
   input  logic [tcw_pkg::BYTE_W-1:0]        req_attribute,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tcw_pkg::POS_W-1:0]         rsp_cursor_position,
   output logic                              rsp_cell_written,
   output logic [tcw_pkg::POS_W-1:0]         rsp_cell_index,
   output logic                              rsp_did_scroll,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int COL_W  = tcw_pkg::COL_W;
   localparam int ROW_W  = tcw_pkg::ROW_W;
   localparam int IDX_W  = tcw_pkg::IDX_W;
   localparam int CELL_W = tcw_pkg::CELL_W;
   localparam int POS_W  = tcw_pkg::POS_W;
   localparam int CELLS  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_CAP = (MAX_COLS > (2**COL_W - 1)) ? (2**COL_W - 1) : MAX_COLS;
   localparam int ROW_CAP = (MAX_ROWS > (2**ROW_W - 1)) ? (2**ROW_W - 1) : MAX_ROWS;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WORK,
      ST_SCROLL,
      ST_DRAIN
   } state_type;

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   columns_ff, columns_in;
   logic [ROW_W-1:0]   rows_ff, rows_in;
   logic [COL_W-1:0]   cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]   cursor_row_ff, cursor_row_in;
   logic [tcw_pkg::BYTE_W-1:0] ch_ff, ch_in;
   logic [tcw_pkg::BYTE_W-1:0] attr_ff, attr_in;
   logic [COL_W-1:0]   item_col_ff, item_col_in;
   logic [ROW_W-1:0]   item_row_ff, item_row_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic               rsp_wr_ff, rsp_wr_in;
   logic [POS_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic               rsp_scr_ff, rsp_scr_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]   sc_ff, sc_in;
   logic [IDX_W-1:0]   sc_cols_ff, sc_cols_in;
   logic [IDX_W-1:0]   keep_ff, keep_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               pend_zero_ff, pend_zero_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0]  rdata_ff;

   logic [CELL_W-1:0]  cell_mem [CELLS];

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;

   logic [COL_W-1:0]   cols;
   logic [ROW_W-1:0]   nrows;
   logic [COL_W-1:0]   sat_col;
   logic [ROW_W-1:0]   sat_row;
   logic               req_accept;
   logic               rsp_take;
   logic               csr_wr;
   logic               newline;
   logic [COL_W:0]     col_inc;
   logic [ROW_W:0]     row_inc;
   logic               wrap;
   logic               scroll;
   logic [IDX_W-1:0]   base;
   logic [IDX_W-1:0]   pos;

   always_comb begin
      if (columns_ff == '0) begin
         cols = COL_W'(1);
      end else if (int'(columns_ff) > COL_CAP) begin
         cols = COL_W'(COL_CAP);
      end else begin
         cols = columns_ff;
      end
      if (rows_ff == '0) begin
         nrows = ROW_W'(1);
      end else if (int'(rows_ff) > ROW_CAP) begin
         nrows = ROW_W'(ROW_CAP);
      end else begin
         nrows = rows_ff;
      end
   end

   assign sat_col = (cursor_col_ff >= cols) ? cols - COL_W'(1) : cursor_col_ff;
   assign sat_row = (cursor_row_ff >= nrows) ? nrows - ROW_W'(1) : cursor_row_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == tcw_pkg::REG_ROWS)
                       ? {{(tcw_pkg::CSR_DATA_W-ROW_W){1'b0}}, rows_ff}
                       : {{(tcw_pkg::CSR_DATA_W-COL_W){1'b0}}, columns_ff};

   assign newline = (ch_ff == tcw_pkg::NEWLINE_CODE);
   assign col_inc = {1'b0, item_col_ff} + (COL_W+1)'(1);
   assign row_inc = {1'b0, item_row_ff} + (ROW_W+1)'(1);
   assign wrap    = newline || (col_inc >= {1'b0, cols});
   assign scroll  = wrap && (row_inc >= {1'b0, nrows});
   assign base    = idx_ff - IDX_W'(item_col_ff);
   assign pos     = !wrap ? idx_ff + IDX_W'(1) : (scroll ? base : base + IDX_W'(cols));

   always_comb begin
      state_in      = state_ff;
      columns_in    = columns_ff;
      rows_in       = rows_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      ch_in         = ch_ff;
      attr_in       = attr_ff;
      item_col_in   = item_col_ff;
      item_row_in   = item_row_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_take;
      rsp_pos_in    = rsp_pos_ff;
      rsp_wr_in     = rsp_wr_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_scr_in    = rsp_scr_ff;
      clr_in        = clr_ff;
      sc_in         = sc_ff;
      sc_cols_in    = sc_cols_ff;
      keep_in       = keep_ff;
      last_in       = last_ff;
      pend_valid_in = pend_valid_ff;
      pend_zero_in  = pend_zero_ff;
      pend_addr_in  = pend_addr_ff;
      mem_we        = 1'b0;
      mem_waddr     = pend_addr_ff;
      mem_wdata     = pend_zero_ff ? '0 : rdata_ff;
      mem_raddr     = ADDR_W'(sc_ff + sc_cols_ff);

      if (csr_wr) begin
         if (csr_paddr[2] == tcw_pkg::REG_ROWS) begin
            rows_in = csr_pwdata[ROW_W-1:0];
         end else begin
            columns_in = csr_pwdata[COL_W-1:0];
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               ch_in       = req_char_code;
               attr_in     = req_attribute;
               item_col_in = sat_col;
               item_row_in = sat_row;
               idx_in      = IDX_W'(sat_row) * IDX_W'(cols) + IDX_W'(sat_col);
               state_in    = ST_WORK;
            end
         end
         ST_WORK: begin
            if (!rsp_valid_ff || rsp_take) begin
               mem_we       = !newline;
               mem_waddr    = ADDR_W'(idx_ff);
               mem_wdata    = {attr_ff, ch_ff};
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos[POS_W-1:0];
               rsp_wr_in    = !newline;
               rsp_idx_in   = newline ? '0 : idx_ff[POS_W-1:0];
               rsp_scr_in   = scroll;
               cursor_col_in = wrap ? '0 : col_inc[COL_W-1:0];
               cursor_row_in = (wrap && !scroll) ? row_inc[ROW_W-1:0] : item_row_ff;
               if (scroll) begin
                  sc_in         = '0;
                  sc_cols_in    = IDX_W'(cols);
                  keep_in       = base;
                  last_in       = base + IDX_W'(cols) - IDX_W'(1);
                  pend_valid_in = 1'b0;
                  state_in      = ST_SCROLL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCROLL: begin
            mem_we        = pend_valid_ff;
            pend_valid_in = 1'b1;
            pend_zero_in  = (sc_ff >= keep_ff);
            pend_addr_in  = ADDR_W'(sc_ff);
            sc_in         = sc_ff + IDX_W'(1);
            if (sc_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            mem_we        = pend_valid_ff;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= cell_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      attr_ff      <= attr_in;
      item_col_ff  <= item_col_in;
      item_row_ff  <= item_row_in;
      idx_ff       <= idx_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_wr_ff    <= rsp_wr_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_scr_ff   <= rsp_scr_in;
      sc_ff        <= sc_in;
      sc_cols_ff   <= sc_cols_in;
      keep_ff      <= keep_in;
      last_ff      <= last_in;
      pend_zero_ff <= pend_zero_in;
      pend_addr_ff <= pend_addr_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         columns_ff    <= tcw_pkg::COLUMNS_RESET;
         rows_ff       <= tcw_pkg::ROWS_RESET;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         clr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         columns_ff    <= columns_in;
         rows_ff       <= rows_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         clr_ff        <= clr_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_written    = rsp_wr_ff;
   assign rsp_cell_index      = rsp_idx_ff;
   assign rsp_did_scroll      = rsp_scr_ff;

endmodule

FILE: hdl/tcw_checker.sv
module tcw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [tcw_pkg::POS_W-1:0]   rsp_cursor_position,
   input logic                        rsp_cell_written,
   input logic [tcw_pkg::POS_W-1:0]   rsp_cell_index
);

   // clearing pass holds off input straight after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not held off after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted without a busy cycle");

   a_result_follows_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in work");

   a_no_cell_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_cell_written) |-> (rsp_cell_index == '0))
      else $error("cell index set with no cell written");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cursor_position)))
      else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_cursor_position (rsp_cursor_position),
   .rsp_cell_written    (rsp_cell_written),
   .rsp_cell_index      (rsp_cell_index)
);
